>>> src/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types for the sorted range table
// Defines the operation and status codes, the request and response payloads,
// and the table entry and transaction records that move along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  localparam int unsigned ADDR_BITS = 32;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_MATCH = 2'd2
  } status_e;

  // Input transaction
  typedef struct packed {
    op_e   operation;
    addr_t address;
    addr_t length;
  } req_t;

  // Output transaction
  typedef struct packed {
    status_e status;
    logic    hit;
    logic    empty_res;
  } rsp_t;

  // One stored region
  typedef struct packed {
    logic  vld;
    addr_t base;
    addr_t len;
  } ent_t;

  // Transaction record that walks the chain, one cell per clock
  typedef struct packed {
    logic  vld;
    op_e   operation;
    addr_t address;
    addr_t length;
    ent_t  carry;   // region being pushed toward the tail on insert
    logic  disp;    // insert point passed: every later cell shifts
    logic  found;   // remove matched: every later cell pulls its neighbor
    logic  hit;     // query covered by some region
    logic  full;    // insert arrived at a full table
  } pkt_t;

endpackage

`default_nettype wire

>>> src/srt_cell.sv
// ----------------------------------------------------------------------------
// srt_cell: one slot of the sorted range table
// Holds one region and applies the passing transaction to it: insert by
// swapping with the carried region, remove by pulling from the right
// neighbor, and query by testing coverage. Hands the transaction on.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire srt_pkg::pkt_t pkt_i,
  input  wire srt_pkg::ent_t nxt_i,
  output srt_pkg::ent_t      ent_o,
  output srt_pkg::pkt_t      pkt_o
);
  import srt_pkg::*;

  logic  vld_q, vld_d;
  addr_t base_q, base_d;
  addr_t len_q, len_d;
  pkt_t  pkt_q, pkt_d;
  ent_t  ent_cur;
  addr_t off;
  logic  covers;
  logic  match;

  assign ent_cur = '{vld: vld_q, base: base_q, len: len_q};

  // Coverage test for a query; only meaningful when base <= address
  assign off    = pkt_i.address - base_q;
  assign covers = vld_q && (base_q <= pkt_i.address) && (pkt_i.length <= len_q)
                  && (off <= (len_q - pkt_i.length));
  assign match  = vld_q && (base_q == pkt_i.address);

  // Apply the transaction to this slot
  always_comb begin
    pkt_d  = pkt_i;
    vld_d  = vld_q;
    base_d = base_q;
    len_d  = len_q;
    if (pkt_i.vld) begin
      unique case (pkt_i.operation)
        OP_INSERT: begin
          if (pkt_i.carry.vld) begin
            if (!vld_q) begin
              vld_d           = 1'b1;
              base_d          = pkt_i.carry.base;
              len_d           = pkt_i.carry.len;
              pkt_d.carry.vld = 1'b0;
            end else if (pkt_i.disp || (base_q >= pkt_i.address)) begin
              base_d      = pkt_i.carry.base;
              len_d       = pkt_i.carry.len;
              pkt_d.carry = ent_cur;
              pkt_d.disp  = 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          if (pkt_i.found || match) begin
            vld_d       = nxt_i.vld;
            base_d      = nxt_i.base;
            len_d       = nxt_i.len;
            pkt_d.found = 1'b1;
          end
        end
        OP_QUERY: begin
          if (covers) begin
            pkt_d.hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold control state and the passing transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      pkt_q <= '0;
    end else begin
      vld_q <= vld_d;
      pkt_q <= pkt_d;
    end
  end

  // Hold region payload
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    len_q  <= len_d;
  end

  assign ent_o = ent_cur;
  assign pkt_o = pkt_q;

endmodule

`default_nettype wire

>>> src/sorted_range_table.sv
// ----------------------------------------------------------------------------
// sorted_range_table: sorted table of regions with insert, remove and query
// Chain of TABLE_DEPTH cells kept sorted ascending by base.
// ----------------------------------------------------------------------------
// Each accepted transaction enters cell 0 in the cycle it is accepted and
// walks the chain one cell per clock; its result is registered in the cycle
// after it leaves the last cell. One transaction is in the chain at a time,
// so the block takes no new transaction until the last one has left the cell
// chain. A finished result waits in the output register (and one skid slot)
// while the next transaction already runs. Inserts into a full table report
// status full and change nothing; a remove that finds no equal base reports
// no match. Regions with equal bases keep newest first.
`default_nettype none

module sorted_range_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire srt_pkg::req_t in_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output srt_pkg::rsp_t      out_o
);
  import srt_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  pkt_t chain [TABLE_DEPTH+1];
  ent_t ents  [TABLE_DEPTH];
  ent_t nxts  [TABLE_DEPTH];

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            flight_q;
  logic            out_vld_q;
  rsp_t            out_q;
  logic            skid_vld_q;
  rsp_t            skid_q;
  logic            accept;
  logic            full;
  logic            done;
  logic            out_free;
  pkt_t            head;
  pkt_t            last;
  rsp_t            res;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = flight_q || skid_vld_q;
  assign full       = (cnt_q == CntW'(TABLE_DEPTH));

  // Launch the transaction into the head cell
  always_comb begin
    head           = '0;
    head.vld       = accept;
    head.operation = in_i.operation;
    head.address   = in_i.address;
    head.length    = in_i.length;
    head.full      = full;
    head.carry.vld = (in_i.operation == OP_INSERT) && !full;
    head.carry.base = in_i.address;
    head.carry.len  = in_i.length;
  end

  assign chain[0] = head;

  // Build the cell chain
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign nxts[g] = '0;
    end else begin : g_mid
      assign nxts[g] = ents[g+1];
    end

    srt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pkt_i  (chain[g]),
      .nxt_i  (nxts[g]),
      .ent_o  (ents[g]),
      .pkt_o  (chain[g+1])
    );
  end

  assign last = chain[TABLE_DEPTH];
  assign done = last.vld;

  // Form the result and the new entry count
  always_comb begin
    cnt_d = cnt_q;
    res   = '{status: ST_OK, hit: 1'b0, empty_res: 1'b0};
    unique case (last.operation)
      OP_INSERT: begin
        if (last.full) begin
          res.status = ST_FULL;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (last.found) begin
          cnt_d = cnt_q - CntW'(1);
        end else begin
          res.status = ST_NO_MATCH;
        end
      end
      OP_QUERY: res.hit = last.hit;
      default: ;
    endcase
    res.empty_res = (cnt_d == '0);
  end

  assign out_free = !out_vld_q || !out_stall_i;

  // Track the transaction in flight, the count and the output slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q   <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        flight_q <= 1'b1;
      end else if (done) begin
        flight_q <= 1'b0;
      end
      if (done) begin
        cnt_q <= cnt_d;
      end
      if (out_free) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= done;
        end else begin
          out_vld_q <= done;
        end
      end else if (done) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  // Move result payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
        if (done) begin
          skid_q <= res;
        end
      end else if (done) begin
        out_q <= res;
      end
    end else if (done) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> src/srt_chk.sv
// ----------------------------------------------------------------------------
// srt_chk: port checks for the sorted range table
// Watches the top level's ports and flags results that cannot occur, plus
// the output hold rule. Bound to every sorted_range_table instance.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_chk (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire srt_pkg::req_t in_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire srt_pkg::rsp_t out_o
);
  import srt_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  // Block input right after a transaction enters the chain
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while one is in the chain");

  // A full table is never empty
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == ST_FULL) |-> !out_o.empty_res)
    else $error("full status with empty table");

  // A hit needs a stored region and an ok status
  a_hit_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.hit |-> (out_o.status == ST_OK) && !out_o.empty_res)
    else $error("hit reported without a stored region");

endmodule

bind sorted_range_table srt_chk u_srt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

`default_nettype wire
